// ===== src/dxt_pkg.sv =====
package dxt_pkg;

  // Largest image side in texels, and the widths that follow from it.
  localparam int MAX_SIDE = 4096;
  localparam int SIDE_W   = $clog2(MAX_SIDE) + 1;
  localparam int BLK_W    = $clog2(MAX_SIDE / 4);
  localparam int BCNT_W   = BLK_W + 1;
  localparam int COORD_W  = 12;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_FORMAT_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

  localparam logic [1:0] MODE_DXT1 = 2'd0;
  localparam logic [1:0] MODE_DXT3 = 2'd1;
  localparam logic [1:0] MODE_DXT5 = 2'd2;

  // One classified block waiting for the texel pass.
  typedef struct packed {
    logic [1:0]       mode;
    logic             four;
    logic [7:0]       r0;
    logic [7:0]       g0;
    logic [7:0]       b0;
    logic [7:0]       r1;
    logic [7:0]       g1;
    logic [7:0]       b1;
    logic [63:0]      aword;
    logic [31:0]      codes;
    logic [15:0]      mask;
    logic [BLK_W-1:0] col;
    logic [BLK_W-1:0] row;
  } blk_entry_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } q_status_t;

endpackage

// ===== src/dxt_front.sv =====
module dxt_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [dxt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dxt_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          first_block,
  input  logic [63:0]                   alpha_word,
  input  logic [63:0]                   color_word,
  input  dxt_pkg::q_status_t            q_stat,
  output logic                          push,
  output dxt_pkg::blk_entry_t           push_entry
);

  logic [1:0]                      format_mode;
  logic [dxt_pkg::SIDE_W-1:0]      image_width;
  logic [dxt_pkg::SIDE_W-1:0]      image_height;
  logic [dxt_pkg::BLK_W-1:0]       block_column;
  logic [dxt_pkg::BLK_W-1:0]       block_row;
  logic [dxt_pkg::BLK_W-1:0]       block_column_next;
  logic [dxt_pkg::BLK_W-1:0]       block_row_next;

  logic [dxt_pkg::SIDE_W-1:0]      w;
  logic [dxt_pkg::SIDE_W-1:0]      h;
  logic [dxt_pkg::SIDE_W:0]        w_sum;
  logic [dxt_pkg::SIDE_W:0]        h_sum;
  logic [dxt_pkg::BCNT_W-1:0]      bw;
  logic [dxt_pkg::BCNT_W-1:0]      bh;
  logic [dxt_pkg::BLK_W-1:0]       col_cur;
  logic [dxt_pkg::BLK_W-1:0]       row_cur;
  logic [dxt_pkg::BCNT_W-1:0]      col_inc;
  logic [dxt_pkg::BCNT_W-1:0]      row_inc;
  logic [3:0]                      col_ok;
  logic [3:0]                      row_ok;
  logic [15:0]                     mask;
  logic [15:0]                     c0;
  logic [15:0]                     c1;
  logic                            accept;

  // v*255/31 = 8v + floor(7v/31); the quotient uses a reciprocal exact for 7v < 256.
  function automatic logic [7:0] expand5(input logic [4:0] v);
    logic [7:0]  v7;
    logic [15:0] p;
    begin
      v7 = 8'(v) * 8'd7;
      p  = 16'(v7) * 16'd265;
      expand5 = {v, 3'b000} + {5'b00000, p[15:13]};
    end
  endfunction

  // v*255/63 = 4v + floor(v/21).
  function automatic logic [7:0] expand6(input logic [5:0] v);
    logic [1:0] q;
    begin
      q = 2'(v >= 6'd21) + 2'(v >= 6'd42) + 2'(v >= 6'd63);
      expand6 = {v, 2'b00} + {6'b000000, q};
    end
  endfunction

  always_comb begin
    if (image_width == '0) begin
      w = dxt_pkg::SIDE_W'(1);
    end else if (image_width > dxt_pkg::SIDE_W'(dxt_pkg::MAX_SIDE)) begin
      w = dxt_pkg::SIDE_W'(dxt_pkg::MAX_SIDE);
    end else begin
      w = image_width;
    end
    if (image_height == '0) begin
      h = dxt_pkg::SIDE_W'(1);
    end else if (image_height > dxt_pkg::SIDE_W'(dxt_pkg::MAX_SIDE)) begin
      h = dxt_pkg::SIDE_W'(dxt_pkg::MAX_SIDE);
    end else begin
      h = image_height;
    end
  end

  assign w_sum = {1'b0, w} + (dxt_pkg::SIDE_W + 1)'(3);
  assign h_sum = {1'b0, h} + (dxt_pkg::SIDE_W + 1)'(3);
  assign bw    = w_sum[dxt_pkg::BCNT_W+1:2];
  assign bh    = h_sum[dxt_pkg::BCNT_W+1:2];

  assign col_cur = first_block ? '0 : block_column;
  assign row_cur = first_block ? '0 : block_row;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      col_ok[j] = {1'b0, col_cur, 2'(j)} < w;
      row_ok[j] = {1'b0, row_cur, 2'(j)} < h;
    end
    for (int i = 0; i < 16; i++) begin
      mask[i] = col_ok[i % 4] & row_ok[i / 4];
    end
  end

  assign col_inc = {1'b0, col_cur} + dxt_pkg::BCNT_W'(1);
  assign row_inc = {1'b0, row_cur} + dxt_pkg::BCNT_W'(1);

  always_comb begin
    if (col_inc >= bw) begin
      block_column_next = '0;
      block_row_next    = (row_inc >= bh) ? '0 : row_inc[dxt_pkg::BLK_W-1:0];
    end else begin
      block_column_next = col_inc[dxt_pkg::BLK_W-1:0];
      block_row_next    = row_cur;
    end
  end

  assign c0 = color_word[15:0];
  assign c1 = color_word[31:16];

  always_comb begin
    push_entry.mode  = format_mode;
    push_entry.four  = (format_mode == dxt_pkg::MODE_DXT3) ||
                       (format_mode == dxt_pkg::MODE_DXT5) || (c0 > c1);
    push_entry.r0    = expand5(c0[15:11]);
    push_entry.g0    = expand6(c0[10:5]);
    push_entry.b0    = expand5(c0[4:0]);
    push_entry.r1    = expand5(c1[15:11]);
    push_entry.g1    = expand6(c1[10:5]);
    push_entry.b1    = expand5(c1[4:0]);
    push_entry.aword = alpha_word;
    push_entry.codes = color_word[63:32];
    push_entry.mask  = mask;
    push_entry.col   = col_cur;
    push_entry.row   = row_cur;
  end

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  // A block that lies wholly outside the image only moves the position.
  assign push     = accept && (mask != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      format_mode  <= dxt_pkg::MODE_DXT1;
      image_width  <= dxt_pkg::SIDE_W'(4);
      image_height <= dxt_pkg::SIDE_W'(4);
      block_column <= '0;
      block_row    <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          dxt_pkg::REG_FORMAT_MODE:  format_mode  <= cfg_data[1:0];
          dxt_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
          dxt_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        block_column <= block_column_next;
        block_row    <= block_row_next;
      end
    end
  end

endmodule

// ===== src/dxt_queue.sv =====
module dxt_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  dxt_pkg::blk_entry_t push_entry,
  input  logic                pop,
  output dxt_pkg::blk_entry_t head,
  output dxt_pkg::q_status_t  stat
);

  dxt_pkg::blk_entry_t ent [2];
  logic                wr_ptr;
  logic                rd_ptr;
  logic [1:0]          count;
  logic                do_push;
  logic                do_pop;

  assign stat.full     = (count == 2'd2);
  assign stat.nonempty = (count != 2'd0);
  assign do_push       = push && !stat.full;
  assign do_pop        = pop && stat.nonempty;
  assign head          = ent[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

// ===== src/dxt_back.sv =====
module dxt_back (
  input  logic                       clk,
  input  logic                       rst,
  input  dxt_pkg::blk_entry_t        head,
  input  dxt_pkg::q_status_t         q_stat,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [7:0]                 blue,
  output logic [7:0]                 green,
  output logic [7:0]                 red,
  output logic [7:0]                 alpha,
  output logic [dxt_pkg::COORD_W-1:0] texel_x,
  output logic [dxt_pkg::COORD_W-1:0] texel_y,
  output logic                       last_texel
);

  localparam logic [1:0] AOP_PASS = 2'd0;
  localparam logic [1:0] AOP_DIV7 = 2'd1;
  localparam logic [1:0] AOP_DIV5 = 2'd2;

  logic [3:0]  idx;
  logic        step;
  logic        emit;
  logic        is_last;
  logic [15:0] rest;
  logic [1:0]  code;
  logic [2:0]  ac;
  logic [3:0]  a4;
  logic [7:0]  a0;
  logic [7:0]  a1;
  logic [3:0]  wa;
  logic [3:0]  wb;
  logic [11:0] pa;
  logic [11:0] pb;

  logic        cop_d;
  logic [9:0]  nb_d;
  logic [9:0]  ng_d;
  logic [9:0]  nr_d;
  logic [1:0]  aop_d;
  logic [10:0] an_d;

  logic                        s1_valid;
  logic                        s1_cop;
  logic [9:0]                  s1_nb;
  logic [9:0]                  s1_ng;
  logic [9:0]                  s1_nr;
  logic [1:0]                  s1_aop;
  logic [10:0]                 s1_an;
  logic [dxt_pkg::COORD_W-1:0] s1_x;
  logic [dxt_pkg::COORD_W-1:0] s1_y;
  logic                        s1_last;
  logic                        s2_load;
  logic                        s1_free;

  function automatic logic [9:0] col_num(input logic [7:0] e0, input logic [7:0] e1,
                                         input logic [1:0] c, input logic four);
    logic [9:0] s;
    begin
      col_num = '0;
      case (c)
        2'd0: col_num = {2'b00, e0};
        2'd1: col_num = {2'b00, e1};
        2'd2: begin
          if (four) begin
            col_num = {1'b0, e0, 1'b0} + {2'b00, e1};
          end else begin
            s = {2'b00, e0} + {2'b00, e1};
            col_num = {1'b0, s[9:1]};
          end
        end
        default: col_num = four ? ({2'b00, e0} + {1'b0, e1, 1'b0}) : 10'd0;
      endcase
    end
  endfunction

  // Truncating quotients by reciprocal; each is exact over its numerator range.
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [19:0] p;
    begin
      p = 20'(x) * 20'd683;
      div3 = p[18:11];
    end
  endfunction

  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [22:0] p;
    begin
      p = 23'(x) * 23'd2341;
      div7 = p[21:14];
    end
  endfunction

  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [22:0] p;
    begin
      p = 23'(x) * 23'd3277;
      div5 = p[21:14];
    end
  endfunction

  assign rest    = head.mask >> idx;
  assign emit    = rest[0];
  assign is_last = (rest[15:1] == '0);
  assign code    = head.codes[2*idx +: 2];
  assign ac      = head.aword[16 + 3*idx +: 3];
  assign a4      = head.aword[4*idx +: 4];
  assign a0      = head.aword[7:0];
  assign a1      = head.aword[15:8];

  assign wa = (a0 > a1) ? (4'd8 - {1'b0, ac}) : (4'd6 - {1'b0, ac});
  assign wb = {1'b0, ac} - 4'd1;
  assign pa = 12'(wa) * 12'(a0);
  assign pb = 12'(wb) * 12'(a1);

  always_comb begin
    cop_d = head.four && code[1];
    nb_d  = col_num(head.b0, head.b1, code, head.four);
    ng_d  = col_num(head.g0, head.g1, code, head.four);
    nr_d  = col_num(head.r0, head.r1, code, head.four);
    aop_d = AOP_PASS;
    an_d  = 11'd255;
    if (head.mode == dxt_pkg::MODE_DXT3) begin
      an_d = {3'b000, a4, a4};
    end else if (head.mode == dxt_pkg::MODE_DXT5) begin
      if (ac == 3'd0) begin
        an_d = {3'b000, a0};
      end else if (ac == 3'd1) begin
        an_d = {3'b000, a1};
      end else if (a0 > a1) begin
        aop_d = AOP_DIV7;
        an_d  = 11'(pa + pb);
      end else if (ac == 3'd6) begin
        an_d = 11'd0;
      end else if (ac == 3'd7) begin
        an_d = 11'd255;
      end else begin
        aop_d = AOP_DIV5;
        an_d  = 11'(pa + pb);
      end
    end else if (!head.four && (code == 2'd3)) begin
      // Transparent black in the three-colour palette.
      an_d = 11'd0;
    end
  end

  assign s2_load = s1_valid && (!out_valid || out_ready);
  assign s1_free = !s1_valid || s2_load;
  assign step    = q_stat.nonempty && s1_free;
  assign pop     = step && emit && is_last;

  always_ff @(posedge clk) begin
    if (step) begin
      s1_cop  <= cop_d;
      s1_nb   <= nb_d;
      s1_ng   <= ng_d;
      s1_nr   <= nr_d;
      s1_aop  <= aop_d;
      s1_an   <= an_d;
      s1_x    <= {head.col, idx[1:0]};
      s1_y    <= {head.row, idx[3:2]};
      s1_last <= is_last;
    end
    if (s2_load) begin
      blue       <= s1_cop ? div3(s1_nb) : s1_nb[7:0];
      green      <= s1_cop ? div3(s1_ng) : s1_ng[7:0];
      red        <= s1_cop ? div3(s1_nr) : s1_nr[7:0];
      texel_x    <= s1_x;
      texel_y    <= s1_y;
      last_texel <= s1_last;
      case (s1_aop)
        AOP_DIV7: alpha <= div7(s1_an);
        AOP_DIV5: alpha <= div5(s1_an);
        default:  alpha <= s1_an[7:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= 4'd0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (step) begin
        idx <= pop ? 4'd0 : idx + 4'd1;
      end
      if (s1_free) begin
        s1_valid <= step && emit;
      end
      if (s2_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== src/dxt_block_texel_decoder_unit.sv =====
// Channel   Direction  Handshake          Payload
// s_*       in         s_tvalid/s_tready  s_tuser first_block, s_tdata alpha, colour words
// m_*       out        m_tvalid/m_tready  m_tdata B,G,R,A,x,y; m_tlast last texel of block
// cfg_*     in         cfg_we             cfg_index, cfg_data
//
// The front expands endpoints and clip mask and queues each block that is not fully clipped.
// The back walks the sixteen texel places one per cycle while the texel pipeline is not held,
// stopping at the last visible texel; texels pass through the s1 and output registers.
// A two-entry queue lets the next blocks enter while the back still works. Synchronous reset
// zeroes the position, sets DXT1 on a 4x4 image and empties the queue and texel pipeline.
// m_tready low with a texel waiting holds the pipeline; s_tready drops only when the queue is full.
module dxt_block_texel_decoder_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [dxt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dxt_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [127:0]                   s_tdata,   // alpha_word, color_word
  input  logic                           s_tuser,   // first_block
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [55:0]                    m_tdata,   // blue, green, red, alpha, texel_x, texel_y
  output logic                           m_tlast    // last_texel
);

  dxt_pkg::blk_entry_t        push_entry;
  dxt_pkg::blk_entry_t        head;
  dxt_pkg::q_status_t         q_stat;
  logic                       push;
  logic                       pop;
  logic [7:0]                 blue;
  logic [7:0]                 green;
  logic [7:0]                 red;
  logic [7:0]                 alpha;
  logic [dxt_pkg::COORD_W-1:0] texel_x;
  logic [dxt_pkg::COORD_W-1:0] texel_y;

  dxt_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .first_block (s_tuser),
    .alpha_word  (s_tdata[63:0]),
    .color_word  (s_tdata[127:64]),
    .q_stat      (q_stat),
    .push        (push),
    .push_entry  (push_entry)
  );

  dxt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .stat       (q_stat)
  );

  dxt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .blue       (blue),
    .green      (green),
    .red        (red),
    .alpha      (alpha),
    .texel_x    (texel_x),
    .texel_y    (texel_y),
    .last_texel (m_tlast)
  );

  assign m_tdata = {texel_y, texel_x, alpha, red, green, blue};

endmodule

// ===== tb/dxt_texel_checker.sv =====
module dxt_texel_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [dxt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dxt_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [127:0]                   s_tdata,   // alpha_word, color_word
  input  logic                           s_tuser,   // first_block
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [55:0]                    m_tdata,   // blue, green, red, alpha, texel_x, texel_y
  input  logic                           m_tlast,   // last_texel
  output int                             texels_pending,
  output int                             mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [7:0]  alpha;
    logic [11:0] x;
    logic [11:0] y;
    logic        last;
  } texel_t;

  logic [1:0]  format_mode;
  logic [12:0] width_reg;
  logic [12:0] height_reg;
  int unsigned blk_col;
  int unsigned blk_row;
  texel_t      expected_texels[$];
  int          fail_count;

  function automatic int unsigned clamp_side(logic [12:0] v);
    if (v == 0) return 1;
    if (v > dxt_pkg::MAX_SIDE) return dxt_pkg::MAX_SIDE;
    return v;
  endfunction

  function automatic void expand565(input int unsigned c, output int unsigned r,
                                    output int unsigned g, output int unsigned b);
    r = ((c >> 11) & 31) * 255 / 31;
    g = ((c >> 5) & 63) * 255 / 63;
    b = (c & 31) * 255 / 31;
  endfunction

  // Works out the texels of one block at the current position and advances it.
  function automatic void decode_block(logic first, logic [63:0] aw, logic [63:0] cw);
    int unsigned w, h, bw, bh, c0, c1, a0, a1, code, sel, av, gx, gy, a4;
    int unsigned pr[4], pg[4], pb[4], pa[4];
    logic        four;
    texel_t      t;
    texel_t      blk[$];
    w = clamp_side(width_reg);
    h = clamp_side(height_reg);
    bw = (w + 3) / 4;
    bh = (h + 3) / 4;
    c0 = cw[15:0];
    c1 = cw[31:16];
    a0 = aw[7:0];
    a1 = aw[15:8];
    four = (format_mode == dxt_pkg::MODE_DXT3) || (format_mode == dxt_pkg::MODE_DXT5) ||
           (c0 > c1);
    if (first) begin
      blk_col = 0;
      blk_row = 0;
    end
    expand565(c0, pr[0], pg[0], pb[0]);
    expand565(c1, pr[1], pg[1], pb[1]);
    for (int k = 0; k < 4; k++) pa[k] = 255;
    if (four) begin
      pr[2] = (2 * pr[0] + pr[1]) / 3;
      pg[2] = (2 * pg[0] + pg[1]) / 3;
      pb[2] = (2 * pb[0] + pb[1]) / 3;
      pr[3] = (pr[0] + 2 * pr[1]) / 3;
      pg[3] = (pg[0] + 2 * pg[1]) / 3;
      pb[3] = (pb[0] + 2 * pb[1]) / 3;
    end else begin
      // Three-colour palette: the fourth entry is transparent black.
      pr[2] = (pr[0] + pr[1]) / 2;
      pg[2] = (pg[0] + pg[1]) / 2;
      pb[2] = (pb[0] + pb[1]) / 2;
      pr[3] = 0;
      pg[3] = 0;
      pb[3] = 0;
      pa[3] = 0;
    end
    for (int i = 0; i < 16; i++) begin
      gx = blk_col * 4 + (i % 4);
      gy = blk_row * 4 + (i / 4);
      code = cw[32 + 2 * i +: 2];
      if (gx >= w || gy >= h) continue;
      case (format_mode)
        dxt_pkg::MODE_DXT3: begin
          a4 = aw[4 * i +: 4];
          av = a4 | (a4 << 4);
        end
        dxt_pkg::MODE_DXT5: begin
          sel = aw[16 + 3 * i +: 3];
          if (sel == 0) av = a0;
          else if (sel == 1) av = a1;
          else if (a0 > a1) av = ((8 - sel) * a0 + (sel - 1) * a1) / 7;
          else if (sel == 6) av = 0;
          else if (sel == 7) av = 255;
          else av = ((6 - sel) * a0 + (sel - 1) * a1) / 5;
        end
        default: av = pa[code];
      endcase
      t.blue  = 8'(pb[code]);
      t.green = 8'(pg[code]);
      t.red   = 8'(pr[code]);
      t.alpha = 8'(av);
      t.x     = 12'(gx);
      t.y     = 12'(gy);
      t.last  = 1'b0;
      blk.push_back(t);
    end
    if (blk.size() > 0) blk[blk.size() - 1].last = 1'b1;
    foreach (blk[k]) expected_texels.push_back(blk[k]);
    blk_col++;
    if (blk_col >= bw) begin
      blk_col = 0;
      blk_row++;
      if (blk_row >= bh) blk_row = 0;
    end
  endfunction

  function automatic void check_field(string name, int unsigned exp_v, int unsigned got_v);
    if (exp_v != got_v) begin
      fail_count++;
      $display("%0t: texel %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
    end
  endfunction

  always @(posedge clk) begin
    texel_t want;
    texel_t got;
    if (rst) begin
      format_mode = dxt_pkg::MODE_DXT1;
      width_reg = 13'd4;
      height_reg = 13'd4;
      blk_col = 0;
      blk_row = 0;
      expected_texels.delete();
      fail_count = 0;
    end else begin
      if (s_tvalid && s_tready) decode_block(s_tuser, s_tdata[63:0], s_tdata[127:64]);
      if (m_tvalid && m_tready) begin
        got.blue  = m_tdata[7:0];
        got.green = m_tdata[15:8];
        got.red   = m_tdata[23:16];
        got.alpha = m_tdata[31:24];
        got.x     = m_tdata[43:32];
        got.y     = m_tdata[55:44];
        got.last  = m_tlast;
        if (expected_texels.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected texel, expected none, got %h", $time, got);
        end else begin
          want = expected_texels.pop_front();
          check_field("blue", want.blue, got.blue);
          check_field("green", want.green, got.green);
          check_field("red", want.red, got.red);
          check_field("alpha", want.alpha, got.alpha);
          check_field("texel_x", want.x, got.x);
          check_field("texel_y", want.y, got.y);
          check_field("last_texel", want.last, got.last);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          dxt_pkg::REG_FORMAT_MODE:  format_mode = cfg_data[1:0];
          dxt_pkg::REG_IMAGE_WIDTH:  width_reg = cfg_data;
          dxt_pkg::REG_IMAGE_HEIGHT: height_reg = cfg_data;
          default: ;
        endcase
      end
    end
    texels_pending <= expected_texels.size();
    mismatches <= fail_count;
  end

endmodule

// ===== tb/tb_dxt_block_texel_decoder_unit.sv =====
module tb_dxt_block_texel_decoder_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int DRAIN_CYCLES    = 64;
  localparam int RANDOM_PHASES   = 10;
  localparam int ITEMS_PER_PHASE = 20;
  localparam int CYCLE_LIMIT     = 500000;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_we = 1'b0;
  logic [dxt_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [dxt_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [127:0]                   s_tdata = '0;   // alpha_word, color_word
  logic                           s_tuser = 1'b0; // first_block
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [55:0]                    m_tdata;        // blue, green, red, alpha, texel_x, texel_y
  logic                           m_tlast;        // last_texel
  int                             texels_pending;
  int                             mismatches;
  int                             cycle_count = 0;
  logic                           steady = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  dxt_block_texel_decoder_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  dxt_texel_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tlast        (m_tlast),
    .texels_pending (texels_pending),
    .mismatches     (mismatches)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Texel sink: a random stall before each item unless the phase runs steady.
  initial begin
    int unsigned gap;
    @(posedge clk iff !rst);
    forever begin
      gap = steady ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [12:0] pick_side();
    if ($urandom_range(0, 5) == 0) return 13'($urandom_range(0, 8191));
    return 13'($urandom_range(1, 24));
  endfunction

  task automatic send_block(logic first, logic [63:0] aw, logic [63:0] cw);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= first;
    s_tdata <= {cw, aw};
    do @(posedge clk); while (!s_tready);
  endtask

  // A block that is fully clipped yields no texel, so a quiet checker does not
  // prove the block is done: give it time to walk any queued blocks.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (texels_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic reconfigure(logic [1:0] mode, logic [12:0] w, logic [12:0] h);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= dxt_pkg::REG_FORMAT_MODE;
    cfg_data <= {11'd0, mode};
    @(posedge clk);
    cfg_index <= dxt_pkg::REG_IMAGE_WIDTH;
    cfg_data <= w;
    @(posedge clk);
    cfg_index <= dxt_pkg::REG_IMAGE_HEIGHT;
    cfg_data <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [63:0] aw;
    logic [63:0] cw;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: DXT1 on a 4x4 image. Index pattern E4 walks codes 0..3.
    send_block(1'b1, rand64(), {32'hE4E4E4E4, 16'h0000, 16'hFFFF});
    send_block(1'b0, rand64(), {32'hE4E4E4E4, 16'hFFFF, 16'h0000});
    send_block(1'b0, rand64(), {32'hFFFFFFFF, 16'h7BEF, 16'h7BEF});
    send_block(1'b0, 64'd0, 64'd0);
    send_block(1'b0, '1, '1);

    reconfigure(dxt_pkg::MODE_DXT3, 13'd4, 13'd4);
    send_block(1'b1, 64'hFEDCBA9876543210, {32'hE4E4E4E4, 16'h07E0, 16'hF800});
    send_block(1'b0, 64'd0, {32'h1B1B1B1B, 16'hFFFF, 16'h0000});
    send_block(1'b0, '1, rand64());

    // Alpha indices 0..7 twice over, both alpha palettes and equal endpoints.
    reconfigure(dxt_pkg::MODE_DXT5, 13'd4, 13'd4);
    send_block(1'b1, {48'hFAC688FAC688, 8'h00, 8'hFF}, rand64());
    send_block(1'b0, {48'hFAC688FAC688, 8'hFF, 8'h00}, rand64());
    send_block(1'b0, {48'hFAC688FAC688, 8'h80, 8'h80}, rand64());
    send_block(1'b0, {48'hFAC688FAC688, 8'h10, 8'hF0}, rand64());

    reconfigure(MODE_SPARE, 13'd4, 13'd4);
    send_block(1'b1, rand64(), {32'hE4E4E4E4, 16'hFFFF, 16'h0000});
    send_block(1'b0, rand64(), {32'hE4E4E4E4, 16'h0000, 16'hFFFF});

    // A 6x5 image clips the right and bottom blocks, then wraps to the top.
    reconfigure(dxt_pkg::MODE_DXT1, 13'd6, 13'd5);
    for (int k = 0; k < 5; k++) send_block(k == 0, rand64(), rand64());

    // Shrinking the image mid-way leaves the next block wholly outside it.
    reconfigure(dxt_pkg::MODE_DXT3, 13'd4096, 13'd4096);
    for (int k = 0; k < 3; k++) send_block(k == 0, rand64(), rand64());
    reconfigure(dxt_pkg::MODE_DXT1, 13'd4, 13'd4);
    send_block(1'b0, rand64(), rand64());
    send_block(1'b0, rand64(), rand64());

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: reconfigure(dxt_pkg::MODE_DXT1, 13'd1, 13'd1);
        1: reconfigure(dxt_pkg::MODE_DXT3, 13'd4096, 13'd4096);
        2: reconfigure(dxt_pkg::MODE_DXT5, 13'd0, 13'd0);
        3: reconfigure(MODE_SPARE, 13'h1FFF, 13'h1FFF);
        4: reconfigure(dxt_pkg::MODE_DXT1, 13'd4096, 13'd1);
        5: reconfigure(dxt_pkg::MODE_DXT5, 13'd1, 13'd4096);
        default: reconfigure(2'($urandom_range(0, 3)), pick_side(), pick_side());
      endcase
      steady = (p % 3 == 2);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        aw = rand64();
        cw = rand64();
        if ($urandom_range(0, 7) == 0) cw[31:16] = cw[15:0];
        if ($urandom_range(0, 7) == 0) aw[15:8] = aw[7:0];
        send_block($urandom_range(0, 9) == 0, aw, cw);
      end
    end
    steady = 1'b0;

    wait_idle();
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/dxt_pkg.sv
src/dxt_front.sv
src/dxt_queue.sv
src/dxt_back.sv
src/dxt_block_texel_decoder_unit.sv
tb/dxt_texel_checker.sv
tb/tb_dxt_block_texel_decoder_unit.sv
